// File: rtl/tnid_pkg.sv
package tnid_pkg;

    // Field widths
    localparam int COORD_W      = 18;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * COORD_W + 1;
    localparam int DIST_W       = SQ_W + 1;
    localparam int PIDX_W       = 10;
    localparam int WEIGHT_W     = 17;
    localparam int CNT_CFG_W    = 11;
    localparam int THR_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_NEAR     = 3;

    // Arithmetic unit widths and step counts
    localparam int ROOT_W       = 27;
    localparam int RECIP_W      = 47;
    localparam int DIVISOR_W    = 48;
    localparam int DIVIDEND_W   = 64;
    localparam int REM_W        = DIVISOR_W + 1;
    localparam int SQRT_STEPS   = 27;
    localparam int DIV_STEPS    = 64;
    localparam int STEP_CNT_W   = 7;
    localparam int RECIP_SHIFT  = 46;

    // Defaults
    localparam int MAX_POINTS_DEF = 1024;
    localparam logic [CNT_CFG_W-1:0] POINT_COUNT_RST = 11'd1024;
    localparam logic [THR_W-1:0]     MATCH_THR_RST   = 16'd43;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE      = 17'd65536;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_THIRD    = 17'd21845;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THR   = 2'd1;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

endpackage

// File: rtl/three_nearest_inverse_distance.sv
// Three-nearest inverse-distance interpolator. Load words (tuser cmd 0) write one
// point into the table. A query word (cmd 1) scans entries 0..point_count-1, the
// count clamped to 3..MAX_POINTS, at one table read per cycle through a four-stage
// distance pipeline, keeps the three nearest (earlier index wins ties), then runs
// one shared bit-serial unit for three square roots (27 steps each), three
// reciprocals and three normalizing divides (64 steps each), and gives three
// result words, nearest first, the third with tlast. A match below the match
// threshold skips the root and divide work; a degenerate query skips the scan.
// s_tready is high only between queries. The table is undefined until written.
module three_nearest_inverse_distance #(
    parameter int MAX_POINTS = tnid_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,  // point_index, coord_x, coord_y, coord_z
    input  logic [1:0]                          s_tuser,  // cmd, degenerate
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // neighbor_index, weight, zero fill
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tnid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tnid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tnid_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_MATCH = 7'b0000100,
        ST_ROOT  = 7'b0001000,
        ST_RECIP = 7'b0010000,
        ST_NORM  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg;

    logic [CNT_CFG_W-1:0] point_count_reg;
    logic [THR_W-1:0]     match_thr_reg;

    logic [3*COORD_W-1:0] mem [MAX_POINTS];
    logic [3*COORD_W-1:0] mem_q_reg;

    logic signed [COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  issue_cnt_reg;
    logic           p1_reg, p2_reg, p3_reg, p4_reg;
    logic [IW-1:0]  i1_reg, i2_reg, i3_reg, i4_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0] d_reg;

    logic [NUM_NEAR-1:0] near_v_reg;
    logic [DIST_W-1:0]   near_d_reg [NUM_NEAR];
    logic [IW-1:0]       near_i_reg [NUM_NEAR];

    logic [ROOT_W-1:0]    r_reg;
    logic [RECIP_W-1:0]   q_reg [NUM_NEAR];
    logic [DIVISOR_W-1:0] sum_reg;
    logic [WEIGHT_W-1:0]  w_reg [NUM_NEAR];
    logic [1:0]           k_reg;
    logic                 launched_reg;

    logic                 m_valid_reg;
    logic [31:0]          m_data_reg;
    logic                 m_last_reg;

    logic s_accept, cfg_accept, is_load, is_query, degen, load_ok, issue_en, drained;
    logic [IW+PIDX_W-1:0] waddr_w;
    logic [31:0]          n_w;
    logic [DIST_W-1:0]    thr_w;
    logic [DIST_W-1:0]    cur_d;
    logic [IW-1:0]        cur_i;
    logic [1:0]           match_k;
    logic                 any_match;
    logic                 out_free;
    logic [IW+PIDX_W-1:0] out_idx_w;
    logic signed [2*DIFF_W-1:0] mx, my, mz;
    logic ins0, ins1, ins2;
    arith_ctl_t           a_ctl;
    logic [DIVIDEND_W-1:0] a_opa;
    logic [DIVISOR_W-1:0]  a_opb;
    logic                 a_done;
    logic [DIVIDEND_W-1:0] a_res;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign is_load    = s_accept && (s_tuser[0] == CMD_LOAD);
    assign is_query   = s_accept && (s_tuser[0] == CMD_QUERY);
    assign degen      = s_tuser[1];
    assign waddr_w    = {{IW{1'b0}}, s_tdata[PIDX_W-1:0]};
    assign load_ok    = is_load && ({22'b0, s_tdata[PIDX_W-1:0]} < 32'(MAX_POINTS));

    // Clamp the point count to the searchable range
    always_comb
    begin
        n_w = {21'b0, point_count_reg};
        if (n_w < 32'(NUM_NEAR))
            n_w = 32'(NUM_NEAR);
        if (n_w > 32'(MAX_POINTS))
            n_w = 32'(MAX_POINTS);
    end

    assign issue_en = (state_reg == ST_SCAN) && (issue_cnt_reg < n_reg);
    assign drained  = !issue_en && !p1_reg && !p2_reg && !p3_reg && !p4_reg;
    assign thr_w    = {{(DIST_W-THR_W){1'b0}}, match_thr_reg};
    assign cur_d    = d_reg;
    assign cur_i    = i4_reg;

    // Decide where the new distance goes in the sorted list
    assign ins0 = !near_v_reg[0] || (cur_d < near_d_reg[0]);
    assign ins1 = !near_v_reg[1] || (cur_d < near_d_reg[1]);
    assign ins2 = !near_v_reg[2] || (cur_d < near_d_reg[2]);

    // Find the first match below the threshold, nearest first
    always_comb
    begin
        any_match = 1'b1;
        match_k   = 2'd0;
        priority if (near_d_reg[0] < thr_w)
            match_k = 2'd0;
        else if (near_d_reg[1] < thr_w)
            match_k = 2'd1;
        else if (near_d_reg[2] < thr_w)
            match_k = 2'd2;
        else
            any_match = 1'b0;
    end

    // Drive the shared arithmetic unit
    always_comb
    begin
        a_ctl.start = ((state_reg == ST_ROOT) || (state_reg == ST_RECIP) ||
                       (state_reg == ST_NORM)) && !launched_reg;
        a_ctl.op    = (state_reg == ST_ROOT) ? OP_SQRT : OP_DIV;
        unique case (state_reg)
            ST_ROOT:
            begin
                a_opa = {{(DIVIDEND_W-DIST_W-16){1'b0}}, near_d_reg[k_reg], 16'b0};
                a_opb = '0;
            end
            ST_RECIP:
            begin
                a_opa = DIVIDEND_W'(1) << RECIP_SHIFT;
                a_opb = {{(DIVISOR_W-ROOT_W){1'b0}}, r_reg};
            end
            default:
            begin
                a_opa = {1'b0, q_reg[k_reg], 16'b0};
                a_opb = sum_reg;
            end
        endcase
    end

    tnid_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (a_ctl),
        .opa    (a_opa),
        .opb    (a_opb),
        .done   (a_done),
        .result (a_res)
    );

    // Write loads and read the table for the scan
    always_ff @(posedge clk)
    begin
        if (load_ok)
            mem[waddr_w[IW-1:0]] <= s_tdata[PIDX_W +: 3*COORD_W];
        mem_q_reg <= mem[issue_cnt_reg[IW-1:0]];
    end

    // Compute differences, squares and the distance
    assign mx = dx_reg * dx_reg;
    assign my = dy_reg * dy_reg;
    assign mz = dz_reg * dz_reg;

    always_ff @(posedge clk)
    begin
        i1_reg <= issue_cnt_reg[IW-1:0];
        i2_reg <= i1_reg;
        i3_reg <= i2_reg;
        i4_reg <= i3_reg;
        dx_reg <= DIFF_W'(signed'(mem_q_reg[0 +: COORD_W])) - DIFF_W'(qx_reg);
        dy_reg <= DIFF_W'(signed'(mem_q_reg[COORD_W +: COORD_W])) - DIFF_W'(qy_reg);
        dz_reg <= DIFF_W'(signed'(mem_q_reg[2*COORD_W +: COORD_W])) - DIFF_W'(qz_reg);
        sx_reg <= mx[SQ_W-1:0];
        sy_reg <= my[SQ_W-1:0];
        sz_reg <= mz[SQ_W-1:0];
        d_reg  <= {1'b0, sx_reg} + {1'b0, sy_reg} + {1'b0, sz_reg};
    end

    // Sequence the query
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= POINT_COUNT_RST;
            match_thr_reg   <= MATCH_THR_RST;
            issue_cnt_reg   <= '0;
            p1_reg          <= 1'b0;
            p2_reg          <= 1'b0;
            p3_reg          <= 1'b0;
            p4_reg          <= 1'b0;
            near_v_reg      <= '0;
            k_reg           <= '0;
            launched_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                if (cfg_index == REG_POINT_COUNT)
                    point_count_reg <= cfg_data[CNT_CFG_W-1:0];
                else if (cfg_index == REG_MATCH_THR)
                    match_thr_reg <= cfg_data;
            end

            p1_reg <= issue_en;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            if (issue_en)
                issue_cnt_reg <= issue_cnt_reg + 1'b1;

            // Drop the output word once taken, unless a new one replaces it
            if (m_valid_reg && m_tready && (state_reg != ST_EMIT))
                m_valid_reg <= 1'b0;

            if (a_ctl.start)
                launched_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (is_query)
                    begin
                        k_reg <= '0;
                        if (degen)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            issue_cnt_reg <= '0;
                            near_v_reg    <= '0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (p4_reg)
                    begin
                        priority if (ins0)
                            near_v_reg <= {near_v_reg[1:0], 1'b1};
                        else if (ins1)
                            near_v_reg <= {near_v_reg[1], 2'b11};
                        else if (ins2)
                            near_v_reg <= 3'b111;
                    end
                    if (drained)
                        state_reg <= ST_MATCH;
                end
                ST_MATCH:
                begin
                    k_reg     <= '0;
                    state_reg <= any_match ? ST_EMIT : ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (a_done)
                    begin
                        launched_reg <= 1'b0;
                        state_reg    <= ST_RECIP;
                    end
                end
                ST_RECIP:
                begin
                    if (a_done)
                    begin
                        launched_reg <= 1'b0;
                        if (k_reg == 2'd2)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_NORM;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_ROOT;
                        end
                    end
                end
                ST_NORM:
                begin
                    if (a_done)
                    begin
                        launched_reg <= 1'b0;
                        if (k_reg == 2'd2)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        if (k_reg == 2'd2)
                            state_reg <= ST_IDLE;
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign out_idx_w = {{PIDX_W{1'b0}}, near_i_reg[k_reg]};

    // Hold query, neighbor list, intermediate results and the output word
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            qx_reg <= signed'(s_tdata[PIDX_W +: COORD_W]);
            qy_reg <= signed'(s_tdata[PIDX_W+COORD_W +: COORD_W]);
            qz_reg <= signed'(s_tdata[PIDX_W+2*COORD_W +: COORD_W]);
            n_reg  <= n_w[CW-1:0];
            if (degen)
            begin
                for (int j = 0; j < NUM_NEAR; j++)
                begin
                    near_i_reg[j] <= '0;
                    w_reg[j]      <= WEIGHT_THIRD;
                end
            end
        end

        if ((state_reg == ST_SCAN) && p4_reg)
        begin
            priority if (ins0)
            begin
                near_d_reg[2] <= near_d_reg[1];
                near_i_reg[2] <= near_i_reg[1];
                near_d_reg[1] <= near_d_reg[0];
                near_i_reg[1] <= near_i_reg[0];
                near_d_reg[0] <= cur_d;
                near_i_reg[0] <= cur_i;
            end
            else if (ins1)
            begin
                near_d_reg[2] <= near_d_reg[1];
                near_i_reg[2] <= near_i_reg[1];
                near_d_reg[1] <= cur_d;
                near_i_reg[1] <= cur_i;
            end
            else if (ins2)
            begin
                near_d_reg[2] <= cur_d;
                near_i_reg[2] <= cur_i;
            end
        end

        if (state_reg == ST_MATCH)
        begin
            sum_reg <= '0;
            for (int j = 0; j < NUM_NEAR; j++)
                w_reg[j] <= (2'(j) == match_k) ? WEIGHT_ONE : '0;
        end

        if ((state_reg == ST_ROOT) && a_done)
            r_reg <= (a_res[ROOT_W-1:0] == '0) ? ROOT_W'(1) : a_res[ROOT_W-1:0];

        if ((state_reg == ST_RECIP) && a_done)
        begin
            q_reg[k_reg] <= a_res[RECIP_W-1:0];
            sum_reg      <= sum_reg + {1'b0, a_res[RECIP_W-1:0]};
        end

        if ((state_reg == ST_NORM) && a_done)
            w_reg[k_reg] <= a_res[WEIGHT_W-1:0];

        if ((state_reg == ST_EMIT) && out_free)
        begin
            m_data_reg <= {5'b0, w_reg[k_reg], out_idx_w[PIDX_W-1:0]};
            m_last_reg <= (k_reg == 2'd2);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
        a_done |-> launched_reg) else $error("arith result with no request");
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= n_reg)) else $error("scan overrun");
    a_list_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |-> (near_v_reg == 3'b111)) else $error("neighbor list short");

endmodule

// File: rtl/tnid_arith.sv
module tnid_arith (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tnid_pkg::arith_ctl_t                ctl,
    input  logic [tnid_pkg::DIVIDEND_W-1:0]     opa,
    input  logic [tnid_pkg::DIVISOR_W-1:0]      opb,
    output logic                                done,
    output logic [tnid_pkg::DIVIDEND_W-1:0]     result
);
    import tnid_pkg::*;

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_CNT_W-1:0]    cnt_reg;
    arith_op_t                op_reg;
    logic [DIVIDEND_W-1:0]    shreg_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIVIDEND_W-1:0]    acc_reg;
    logic [DIVISOR_W-1:0]     dvs_reg;

    logic [REM_W-1:0]         rem_shift;
    logic [REM_W-1:0]         trial;
    logic                     fits;
    logic [STEP_CNT_W-1:0]    last_step;

    // Form the shifted remainder and trial value for one step
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_shift = {rem_reg[REM_W-3:0], shreg_reg[DIVIDEND_W-1 -: 2]};
            trial     = {acc_reg[REM_W-3:0], 2'b01};
            last_step = STEP_CNT_W'(SQRT_STEPS - 1);
        end
        else
        begin
            rem_shift = {rem_reg[REM_W-2:0], shreg_reg[DIVIDEND_W-1]};
            trial     = {1'b0, dvs_reg};
            last_step = STEP_CNT_W'(DIV_STEPS - 1);
        end
        fits = (rem_shift >= trial);
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands and advance one digit per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg    <= ctl.op;
            shreg_reg <= (ctl.op == OP_SQRT) ? (opa << 10) : opa;
            dvs_reg   <= opb;
            rem_reg   <= '0;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shreg_reg <= (op_reg == OP_SQRT) ? (shreg_reg << 2) : (shreg_reg << 1);
            rem_reg   <= fits ? (rem_shift - trial) : rem_shift;
            acc_reg   <= {acc_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !ctl.start) else $error("arith start while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("arith done without run");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= STEP_CNT_W'(DIV_STEPS - 1))) else $error("arith count overrun");

endmodule
